// ===== rtl/npt_pkg.sv =====
package npt_pkg;

    localparam int FIELD_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int EPS_W      = 17;
    localparam int ACC_W      = 128;
    localparam int OPD_W      = 64;
    localparam int REGION_W   = 3;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);
    localparam logic [OPD_W-1:0] Q_SAT     = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QX  = 2'd0,
        CFG_QY  = 2'd1,
        CFG_QZ  = 2'd2,
        CFG_EPS = 2'd3
    } t_cfg_idx;

    typedef enum logic [REGION_W-1:0] {
        REG_VA  = 3'd0,
        REG_VB  = 3'd1,
        REG_EAB = 3'd2,
        REG_VC  = 3'd3,
        REG_EAC = 3'd4,
        REG_EBC = 3'd5,
        REG_INT = 3'd6
    } t_region;

    // MAC groups, in program order
    typedef enum logic [3:0] {
        G_D1 = 4'd0,
        G_D2 = 4'd1,
        G_D3 = 4'd2,
        G_D4 = 4'd3,
        G_D5 = 4'd4,
        G_D6 = 4'd5,
        G_VC = 4'd6,
        G_VB = 4'd7,
        G_VA = 4'd8,
        G_PX = 4'd9,
        G_PY = 4'd10,
        G_PZ = 4'd11,
        G_DN = 4'd12,
        G_DO = 4'd13
    } t_grp;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_MAC   = 3'd1,
        S_DEC   = 3'd2,
        S_DLOAD = 3'd3,
        S_DIV   = 3'd4,
        S_DFIN  = 3'd5,
        S_OUT   = 3'd6
    } t_state;

    // degenerate edge denominator is replaced by +epsilon
    function automatic logic signed [OPD_W-1:0] edge_den(
        input logic signed [OPD_W-1:0] den,
        input logic [EPS_W-1:0]        e
    );
        logic signed [OPD_W-1:0] es;
        es = $signed(OPD_W'(e));
        if (den < es && den > -es) begin
            return es;
        end
        return den;
    endfunction

endpackage

// ===== rtl/npt_tri_if.sv =====
interface npt_tri_if;
    import npt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] a_x;
    logic signed [FIELD_W-1:0] a_y;
    logic signed [FIELD_W-1:0] a_z;
    logic signed [FIELD_W-1:0] b_x;
    logic signed [FIELD_W-1:0] b_y;
    logic signed [FIELD_W-1:0] b_z;
    logic signed [FIELD_W-1:0] c_x;
    logic signed [FIELD_W-1:0] c_y;
    logic signed [FIELD_W-1:0] c_z;
    logic                      restart;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, restart,
                    input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, restart,
                    output ready);
endinterface

// ===== rtl/npt_res_if.sv =====
interface npt_res_if;
    import npt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] tri_near_x;
    logic signed [FIELD_W-1:0] tri_near_y;
    logic signed [FIELD_W-1:0] tri_near_z;
    logic [REGION_W-1:0]       region;
    logic signed [FIELD_W-1:0] best_x;
    logic signed [FIELD_W-1:0] best_y;
    logic signed [FIELD_W-1:0] best_z;
    logic                      best_changed;

    modport source (output valid, tri_near_x, tri_near_y, tri_near_z, region,
                    best_x, best_y, best_z, best_changed, input ready);
    modport sink   (input valid, tri_near_x, tri_near_y, tri_near_z, region,
                    best_x, best_y, best_z, best_changed, output ready);
endinterface

// ===== rtl/nearest_point_on_triangles_top.sv =====
// Closest point on a triangle to a query point, plus running nearest point.
// Channels: i_tri carries one triangle (vertices A, B, C, signed fixed
// point with FRAC_BITS fraction bits) and a restart flag; o_res returns one
// result per triangle: the closest point on it, its Voronoi region, the
// nearest point since the last restart and a flag when that point changed.
// The query point and epsilon sit in registers written through i_cfg_*; the
// user must write them only while the block is idle; the block does not check.
//
// Every product runs on one shared multiplier, a 32x32 unit that builds a
// signed 64x64 product in four steps and adds it into a 128-bit accumulator
// on a fifth (36 such MACs per triangle), and every quotient on one radix-2
// restoring divider that retires one quotient bit per cycle.
// i_tri.ready is high only when the sequencer is idle, so a new triangle is
// taken only after the previous one has left the sequencer.
//
// The result sits in an output register, so the next triangle is taken while
// it waits; if o_res stalls, the next triangle finishes and holds until the
// register frees. Reset clears the sequencer, the output valid, the nearest
// point (to zero, with no nearest yet), the query (zero) and epsilon (66).
module nearest_point_on_triangles_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [npt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [npt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    npt_tri_if.sink                          i_tri,
    npt_res_if.source                        o_res
);
    import npt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;   // coordinate differences
    localparam logic signed [ACC_W-1:0] C_ONE = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] C_MAX = (C_ONE <<< (CW - 1)) - C_ONE;
    localparam logic signed [ACC_W-1:0] C_MIN = -C_MAX - C_ONE;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [ACC_W-1:0] w);
        logic signed [CW-1:0] res;
        if (w > C_MAX) begin
            res = CW'(C_MAX);
        end else if (w < C_MIN) begin
            res = CW'(C_MIN);
        end else begin
            res = CW'(w);
        end
        return res;
    endfunction

    // configuration
    logic signed [FIELD_W-1:0] r_qx, r_qy, r_qz;
    logic [EPS_W-1:0]          r_eps;

    // triangle and sequencer
    logic signed [CW-1:0] r_a [3];
    logic signed [CW-1:0] r_b [3];
    logic signed [CW-1:0] r_c [3];
    logic                 r_restart;
    t_state               r_state, n_state;
    t_grp                 r_grp;
    logic [1:0]           r_k;
    logic [2:0]           r_sub;

    // MAC unit
    logic [ACC_W-1:0]        r_prod;
    logic signed [ACC_W-1:0] r_acc;

    // intermediate results
    logic signed [OPD_W-1:0] r_d [6];
    logic signed [ACC_W-1:0] r_va, r_vb, r_vc, r_isum;
    t_region                 r_region;
    logic signed [OPD_W-1:0] r_s, r_t;
    logic signed [CW-1:0]    r_pt [3];
    logic [OPD_W-1:0]        r_dn, r_dold;

    // divider
    logic [ACC_W-1:0] r_num, r_den, r_rem, r_quo;
    logic             r_dneg;
    logic [6:0]       r_dcnt;
    logic             r_div2;

    // running nearest
    logic signed [CW-1:0] r_np [3];
    logic                 r_have;

    // output register
    logic                      r_ovalid;
    logic signed [FIELD_W-1:0] r_o_tx, r_o_ty, r_o_tz, r_o_bx, r_o_by, r_o_bz;
    logic [REGION_W-1:0]       r_o_region;
    logic                      r_o_changed;

    // ---------------------------------------------------------------
    // vectors
    logic signed [CW-1:0] p [3];
    logic signed [DW-1:0] ab [3], ac [3], bc [3], ap [3], bp [3], cp [3];
    logic signed [DW-1:0] qpt [3], qnp [3], uvec [3];
    logic signed [CW-1:0] base [3];

    always_comb begin
        p[0] = sat_cw(ACC_W'(r_qx));
        p[1] = sat_cw(ACC_W'(r_qy));
        p[2] = sat_cw(ACC_W'(r_qz));
        for (int i = 0; i < 3; i++) begin
            ab[i]  = DW'(r_b[i]) - DW'(r_a[i]);
            ac[i]  = DW'(r_c[i]) - DW'(r_a[i]);
            bc[i]  = DW'(r_c[i]) - DW'(r_b[i]);
            ap[i]  = DW'(p[i]) - DW'(r_a[i]);
            bp[i]  = DW'(p[i]) - DW'(r_b[i]);
            cp[i]  = DW'(p[i]) - DW'(r_c[i]);
            qpt[i] = DW'(p[i]) - DW'(r_pt[i]);
            qnp[i] = DW'(p[i]) - DW'(r_np[i]);
            case (r_region)
                REG_EBC: uvec[i] = bc[i];
                REG_EAC: uvec[i] = ac[i];
                default: uvec[i] = ab[i];
            endcase
            case (r_region)
                REG_VB, REG_EBC: base[i] = r_b[i];
                REG_VC:          base[i] = r_c[i];
                default:         base[i] = r_a[i];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // operand selection for the current MAC term
    logic [1:0]              c_idx;
    logic signed [OPD_W-1:0] mx, my;
    logic                    msub, mfirst, mlast;

    always_comb begin
        case (r_grp)
            G_PY:    c_idx = 2'd1;
            G_PZ:    c_idx = 2'd2;
            default: c_idx = 2'd0;
        endcase
        msub   = 1'b0;
        mfirst = (r_k == 2'd0);
        case (r_grp)
            G_VC, G_VB, G_VA, G_PX, G_PY, G_PZ: mlast = (r_k == 2'd1);
            default:                            mlast = (r_k == 2'd2);
        endcase
        case (r_grp)
            G_D1: begin mx = OPD_W'(ab[r_k]); my = OPD_W'(ap[r_k]); end
            G_D2: begin mx = OPD_W'(ac[r_k]); my = OPD_W'(ap[r_k]); end
            G_D3: begin mx = OPD_W'(ab[r_k]); my = OPD_W'(bp[r_k]); end
            G_D4: begin mx = OPD_W'(ac[r_k]); my = OPD_W'(bp[r_k]); end
            G_D5: begin mx = OPD_W'(ab[r_k]); my = OPD_W'(cp[r_k]); end
            G_D6: begin mx = OPD_W'(ac[r_k]); my = OPD_W'(cp[r_k]); end
            // vc = d1*d4 - d3*d2
            G_VC: begin
                mx   = r_k[0] ? r_d[2] : r_d[0];
                my   = r_k[0] ? r_d[1] : r_d[3];
                msub = r_k[0];
            end
            // vb = d5*d2 - d1*d6
            G_VB: begin
                mx   = r_k[0] ? r_d[0] : r_d[4];
                my   = r_k[0] ? r_d[5] : r_d[1];
                msub = r_k[0];
            end
            // va = d3*d6 - d5*d4
            G_VA: begin
                mx   = r_k[0] ? r_d[4] : r_d[2];
                my   = r_k[0] ? r_d[3] : r_d[5];
                msub = r_k[0];
            end
            G_PX, G_PY, G_PZ: begin
                mx = r_k[0] ? OPD_W'(ac[c_idx]) : OPD_W'(uvec[c_idx]);
                my = r_k[0] ? r_t : r_s;
            end
            G_DN: begin mx = OPD_W'(qpt[r_k]); my = OPD_W'(qpt[r_k]); end
            G_DO: begin mx = OPD_W'(qnp[r_k]); my = OPD_W'(qnp[r_k]); end
            default: begin mx = '0; my = '0; end
        endcase
    end

    // ---------------------------------------------------------------
    // multiplier: magnitude 64x64 in four 32x32 steps
    logic [OPD_W-1:0]        ux, uy;
    logic [31:0]             xa, ya;
    logic [OPD_W-1:0]        pp;
    logic [ACC_W-1:0]        pp_sh;
    logic                    mneg;
    logic signed [ACC_W-1:0] pterm, n_acc, sh, pt_sum;
    logic signed [CW-1:0]    pt_new;
    logic [OPD_W-1:0]        dsq;

    always_comb begin
        ux = mx[OPD_W-1] ? OPD_W'(-mx) : OPD_W'(mx);
        uy = my[OPD_W-1] ? OPD_W'(-my) : OPD_W'(my);
        xa = r_sub[1] ? ux[63:32] : ux[31:0];
        ya = r_sub[0] ? uy[63:32] : uy[31:0];
        pp = OPD_W'(xa) * OPD_W'(ya);
        if (r_sub[1] && r_sub[0]) begin
            pp_sh = {pp, 64'd0};
        end else if (r_sub[1] || r_sub[0]) begin
            pp_sh = {32'd0, pp, 32'd0};
        end else begin
            pp_sh = {64'd0, pp};
        end
        mneg   = mx[OPD_W-1] ^ my[OPD_W-1] ^ msub;
        pterm  = mneg ? -$signed(r_prod) : $signed(r_prod);
        n_acc  = (mfirst ? '0 : r_acc) + pterm;
        sh     = n_acc >>> FRAC_BITS;
        pt_sum = sh + ACC_W'(base[c_idx]);
        pt_new = sat_cw(pt_sum);
        dsq    = (sh[127:64] != '0) ? '1 : sh[63:0];
    end

    // ---------------------------------------------------------------
    // region decision
    t_region dec_region;
    logic    dec_div;
    logic signed [OPD_W-1:0] d43, d56;

    always_comb begin
        d43 = r_d[3] - r_d[2];
        d56 = r_d[4] - r_d[5];
        if (r_d[0] <= 0 && r_d[1] <= 0) begin
            dec_region = REG_VA;
        end else if (r_d[2] >= 0 && r_d[3] <= r_d[2]) begin
            dec_region = REG_VB;
        end else if (r_vc <= 0 && r_d[0] >= 0 && r_d[2] <= 0) begin
            dec_region = REG_EAB;
        end else if (r_d[5] >= 0 && r_d[4] <= r_d[5]) begin
            dec_region = REG_VC;
        end else if (r_vb <= 0 && r_d[1] >= 0 && r_d[5] <= 0) begin
            dec_region = REG_EAC;
        end else if (r_va <= 0 && d43 >= 0 && d56 >= 0) begin
            dec_region = REG_EBC;
        end else begin
            dec_region = REG_INT;
        end
        dec_div = (dec_region == REG_EAB) || (dec_region == REG_EAC) ||
                  (dec_region == REG_EBC) || (dec_region == REG_INT);
    end

    // ---------------------------------------------------------------
    // divider operands
    logic [EPS_W-1:0]        eps_v;
    logic signed [ACC_W-1:0] e16, imag, idn, dnum, dden;
    logic [ACC_W-1:0]        nmag, dmag;

    always_comb begin
        eps_v = (r_eps == '0) ? EPS_W'(1) : r_eps;
        e16   = ACC_W'(eps_v) << FRAC_BITS;
        imag  = r_isum[ACC_W-1] ? -r_isum : r_isum;
        idn   = (imag < e16) ? e16 : r_isum;
        case (r_region)
            REG_EAB: begin
                dnum = ACC_W'(r_d[0]);
                dden = ACC_W'(edge_den(r_d[0] - r_d[2], eps_v));
            end
            REG_EAC: begin
                dnum = ACC_W'(r_d[1]);
                dden = ACC_W'(edge_den(r_d[1] - r_d[5], eps_v));
            end
            REG_EBC: begin
                dnum = ACC_W'(d43);
                dden = ACC_W'(edge_den(d43 + d56, eps_v));
            end
            default: begin
                dnum = r_div2 ? r_vc : r_vb;
                dden = idn;
            end
        endcase
        nmag = dnum[ACC_W-1] ? ACC_W'(-dnum) : ACC_W'(dnum);
        dmag = dden[ACC_W-1] ? ACC_W'(-dden) : ACC_W'(dden);
    end

    logic [ACC_W:0]          r2, rdiff;
    logic                    dge;
    logic [OPD_W-1:0]        qsat;
    logic signed [OPD_W-1:0] qres;

    always_comb begin
        r2    = {r_rem, r_num[ACC_W-1]};
        rdiff = r2 - {1'b0, r_den};
        dge   = (r2 >= {1'b0, r_den});
        qsat  = (r_quo[127:63] != '0) ? Q_SAT : r_quo[63:0];
        qres  = r_dneg ? -$signed(qsat) : $signed(qsat);
    end

    // ---------------------------------------------------------------
    // sequencer
    logic in_xfer, out_load, take;

    assign in_xfer  = i_tri.valid && i_tri.ready;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_res.ready);
    assign take     = r_restart || !r_have || (r_dn < r_dold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_tri.valid) n_state = S_MAC;
            end
            S_MAC: begin
                if (r_sub[2] && mlast) begin
                    if (r_grp == G_VA) n_state = S_DEC;
                    else if (r_grp == G_DO) n_state = S_OUT;
                end
            end
            S_DEC:   n_state = dec_div ? S_DLOAD : S_MAC;
            S_DLOAD: n_state = S_DIV;
            S_DIV: begin
                if (&r_dcnt) n_state = S_DFIN;
            end
            S_DFIN:  n_state = (r_region == REG_INT && !r_div2) ? S_DLOAD : S_MAC;
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx     <= '0;
            r_qy     <= '0;
            r_qz     <= '0;
            r_eps    <= EPS_RESET;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) r_np[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_QX:  r_qx  <= $signed(i_cfg_data);
                    CFG_QY:  r_qy  <= $signed(i_cfg_data);
                    CFG_QZ:  r_qz  <= $signed(i_cfg_data);
                    CFG_EPS: r_eps <= i_cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_have   <= 1'b1;
                if (take) begin
                    for (int i = 0; i < 3; i++) r_np[i] <= r_pt[i];
                end
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_a[0]    <= sat_cw(ACC_W'(i_tri.a_x));
                    r_a[1]    <= sat_cw(ACC_W'(i_tri.a_y));
                    r_a[2]    <= sat_cw(ACC_W'(i_tri.a_z));
                    r_b[0]    <= sat_cw(ACC_W'(i_tri.b_x));
                    r_b[1]    <= sat_cw(ACC_W'(i_tri.b_y));
                    r_b[2]    <= sat_cw(ACC_W'(i_tri.b_z));
                    r_c[0]    <= sat_cw(ACC_W'(i_tri.c_x));
                    r_c[1]    <= sat_cw(ACC_W'(i_tri.c_y));
                    r_c[2]    <= sat_cw(ACC_W'(i_tri.c_z));
                    r_restart <= i_tri.restart;
                end
                r_grp <= G_D1;
                r_k   <= '0;
                r_sub <= '0;
            end
            S_MAC: begin
                if (!r_sub[2]) begin
                    r_prod <= ((r_sub == 3'd0) ? '0 : r_prod) + pp_sh;
                    r_sub  <= r_sub + 3'd1;
                end else begin
                    r_acc <= n_acc;
                    r_sub <= '0;
                    if (mlast) begin
                        r_k <= '0;
                        if (r_grp != G_DO) r_grp <= t_grp'(r_grp + 4'd1);
                        case (r_grp)
                            G_D1, G_D2, G_D3, G_D4, G_D5, G_D6:
                                r_d[r_grp[2:0]] <= sh[63:0];
                            G_VC: r_vc <= n_acc;
                            G_VB: r_vb <= n_acc;
                            G_VA: r_va <= n_acc;
                            G_PX, G_PY, G_PZ: r_pt[c_idx] <= pt_new;
                            G_DN: r_dn <= dsq;
                            G_DO: r_dold <= dsq;
                            default: ;
                        endcase
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
            end
            S_DEC: begin
                // vertex regions leave both weights at zero: point = base
                r_region <= dec_region;
                r_isum   <= r_va + r_vb + r_vc;
                r_s      <= '0;
                r_t      <= '0;
                r_div2   <= 1'b0;
                r_grp    <= G_PX;
                r_k      <= '0;
                r_sub    <= '0;
            end
            S_DLOAD: begin
                r_num  <= nmag << FRAC_BITS;
                r_den  <= dmag;
                r_rem  <= '0;
                r_quo  <= '0;
                r_dneg <= dnum[ACC_W-1] ^ dden[ACC_W-1];
                r_dcnt <= '0;
            end
            S_DIV: begin
                r_rem  <= dge ? rdiff[ACC_W-1:0] : r2[ACC_W-1:0];
                r_quo  <= {r_quo[ACC_W-2:0], dge};
                r_num  <= r_num << 1;
                r_dcnt <= r_dcnt + 7'd1;
            end
            S_DFIN: begin
                if (r_div2) r_t <= qres;
                else        r_s <= qres;
                r_div2 <= 1'b1;
                r_grp  <= G_PX;
                r_k    <= '0;
                r_sub  <= '0;
            end
            S_OUT: begin
                if (out_load) begin
                    r_o_tx      <= FIELD_W'(r_pt[0]);
                    r_o_ty      <= FIELD_W'(r_pt[1]);
                    r_o_tz      <= FIELD_W'(r_pt[2]);
                    r_o_bx      <= take ? FIELD_W'(r_pt[0]) : FIELD_W'(r_np[0]);
                    r_o_by      <= take ? FIELD_W'(r_pt[1]) : FIELD_W'(r_np[1]);
                    r_o_bz      <= take ? FIELD_W'(r_pt[2]) : FIELD_W'(r_np[2]);
                    r_o_region  <= r_region;
                    r_o_changed <= take;
                end
            end
            default: ;
        endcase
    end

    assign i_tri.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_ovalid;
    assign o_res.tri_near_x   = r_o_tx;
    assign o_res.tri_near_y   = r_o_ty;
    assign o_res.tri_near_z   = r_o_tz;
    assign o_res.region       = r_o_region;
    assign o_res.best_x       = r_o_bx;
    assign o_res.best_y       = r_o_by;
    assign o_res.best_z       = r_o_bz;
    assign o_res.best_changed = r_o_changed;

endmodule

// ===== rtl/npt_chk.sv =====
module npt_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [npt_pkg::REGION_W-1:0]      i_region,
    input logic signed [npt_pkg::FIELD_W-1:0] i_tri_x,
    input logic signed [npt_pkg::FIELD_W-1:0] i_tri_y,
    input logic signed [npt_pkg::FIELD_W-1:0] i_tri_z,
    input logic signed [npt_pkg::FIELD_W-1:0] i_best_x,
    input logic signed [npt_pkg::FIELD_W-1:0] i_best_y,
    input logic signed [npt_pkg::FIELD_W-1:0] i_best_z,
    input logic                              i_best_changed
);
    import npt_pkg::*;

    // one triangle in work: input closes right after a transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_region) && $stable(i_tri_x) && $stable(i_best_x)))
        else $error("stalled result changed");

    a_region_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_region <= REG_INT))
        else $error("region code out of range");

    a_best_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_best_changed) |->
            (i_best_x == i_tri_x && i_best_y == i_tri_y && i_best_z == i_tri_z))
        else $error("new nearest differs from triangle point");

endmodule

bind nearest_point_on_triangles_top npt_chk u_npt_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_tri.valid),
    .i_in_ready     (i_tri.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_region       (o_res.region),
    .i_tri_x        (o_res.tri_near_x),
    .i_tri_y        (o_res.tri_near_y),
    .i_tri_z        (o_res.tri_near_z),
    .i_best_x       (o_res.best_x),
    .i_best_y       (o_res.best_y),
    .i_best_z       (o_res.best_z),
    .i_best_changed (o_res.best_changed)
);
